// File: rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPLY_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pee_pkg.sv
// Shared types, codes and decode functions of the postfix evaluator.
// No dependencies; pee_div, pee_dp, pee_ctrl and the top level import this package.
package pee_pkg;

	localparam int DATA_W    = 32;
	localparam int DIV_CNT_W = $clog2(DATA_W);

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [2:0]        status_t;
	typedef logic [7:0]        char_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_INVALID   = 3'd1;
	localparam status_t ST_UNDERFLOW = 3'd2;
	localparam status_t ST_DIVZERO   = 3'd3;
	localparam status_t ST_OVERFLOW  = 3'd4;

	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_STAR  = 8'h2A;
	localparam char_t CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;
	typedef enum logic [1:0] {CL_DIGIT, CL_SPACE, CL_OP, CL_INVALID} cls_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    push;
		logic    load_op;
		logic    alu_wb;
		logic    div_start;
		logic    div_wb;
		logic    set_err;
		status_t err_code;
		logic    finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cls_t cls;
		op_t  op;
		logic err_set;
		logic empty;
		logic lt2;
		logic full;
		logic rhs_zero;
		logic div_done;
	} sts_t;

	function automatic cls_t char_class(char_t c);
		cls_t r;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = CL_DIGIT;
		end else if (c == CH_SPACE) begin
			r = CL_SPACE;
		end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
			r = CL_OP;
		end else begin
			r = CL_INVALID;
		end
		return r;
	endfunction

	function automatic op_t char_op(char_t c);
		op_t r;
		case (c)
			CH_PLUS:  r = OP_ADD;
			CH_MINUS: r = OP_SUB;
			CH_STAR:  r = OP_MUL;
			default:  r = OP_DIV;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/pee_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/pee_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pee_pkg.
module pee_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pee_pkg::word_t dividend,
	input  pee_pkg::word_t divisor,
	output logic          done,
	output pee_pkg::word_t quotient
);
	import pee_pkg::*;

	logic                 busy_q;
	logic                 fix_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [DATA_W:0]      rem_q;
	word_t                quo_q;
	word_t                dvs_q;
	logic [DATA_W:0]      rem_sh;
	logic [DATA_W:0]      diff;

	assign rem_sh = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fix_q;
			fix_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			rem_q <= '0;
			quo_q <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end else if (fix_q) begin
			quo_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/pee_dp.sv
// Datapath: top-of-stack register, stack RAM, ALU, divider, error and result registers.
// Depends on pee_pkg, pee_ram and pee_div.
module pee_dp #(
	parameter int STACK_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pee_pkg::char_t   character,
	input  pee_pkg::cmd_t    cmd,
	output pee_pkg::sts_t    sts,
	output pee_pkg::word_t   value,
	output pee_pkg::status_t status
);
	import pee_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = $clog2(STACK_DEPTH);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] wr_ptr;
	logic [CNT_W-1:0] rd_ptr;
	word_t            tos_q;
	status_t          err_q;
	op_t              op_q;
	word_t            rd_data;
	word_t            alu_res;
	word_t            div_res;
	logic             div_done;
	word_t            out_value_q;
	status_t          out_status_q;
	logic             empty;

	// The top value lives in tos_q; the RAM holds the values below it.
	assign wr_ptr = count_q - CNT_W'(1);
	assign rd_ptr = count_q - CNT_W'(2);
	assign empty  = (count_q == '0);

	pee_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push && !empty),
		.waddr (wr_ptr[AW-1:0]),
		.wdata (tos_q),
		.raddr (rd_ptr[AW-1:0]),
		.rdata (rd_data)
	);

	pee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_data),
		.divisor  (tos_q),
		.done     (div_done),
		.quotient (div_res)
	);

	always_comb begin
		case (op_q)
			OP_ADD:  alu_res = rd_data + tos_q;
			OP_SUB:  alu_res = rd_data - tos_q;
			OP_MUL:  alu_res = rd_data * tos_q;
			default: alu_res = rd_data + tos_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= ST_OK;
		end else begin
			if (cmd.finish) begin
				count_q <= '0;
				err_q   <= ST_OK;
			end else begin
				if (cmd.push) begin
					count_q <= count_q + CNT_W'(1);
				end else if (cmd.alu_wb || cmd.div_wb) begin
					count_q <= count_q - CNT_W'(1);
				end
				if (cmd.set_err && err_q == ST_OK) begin
					err_q <= cmd.err_code;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			tos_q <= word_t'(character - CH_ZERO);
		end else if (cmd.alu_wb) begin
			tos_q <= alu_res;
		end else if (cmd.div_wb) begin
			tos_q <= div_res;
		end
		if (cmd.load_op) begin
			op_q <= char_op(character);
		end
		if (cmd.finish) begin
			out_value_q  <= (err_q == ST_OK && !empty) ? tos_q : '0;
			out_status_q <= (err_q != ST_OK) ? err_q : (empty ? ST_UNDERFLOW : ST_OK);
		end
	end

	assign sts.cls      = char_class(character);
	assign sts.op       = op_q;
	assign sts.err_set  = (err_q != ST_OK);
	assign sts.empty    = empty;
	assign sts.lt2      = (count_q < CNT_W'(2));
	assign sts.full     = (count_q == CNT_W'(STACK_DEPTH));
	assign sts.rhs_zero = (tos_q == '0);
	assign sts.div_done = div_done;

	assign value  = out_value_q;
	assign status = out_status_q;

endmodule

// File: rtl/pee_ctrl.sv
// Controller state machine: sequences one character at a time and owns both handshakes.
// Depends on pee_pkg.
module pee_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tlast,
	input  logic          m_tready,
	input  pee_pkg::sts_t sts,
	output logic          s_tready,
	output logic          m_tvalid,
	output pee_pkg::cmd_t cmd
);
	import pee_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_DIV    = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [1:0] after_op;
	logic       last_q;
	logic       last_d;
	logic       out_valid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign after_op = last_q ? S_FINISH : S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		last_d  = last_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					last_d  = s_tlast;
					state_d = s_tlast ? S_FINISH : S_IDLE;
					// Once an error is latched the rest of the expression is ignored.
					if (!sts.err_set) begin
						case (sts.cls)
							CL_DIGIT: begin
								if (sts.full) begin
									cmd.set_err  = 1'b1;
									cmd.err_code = ST_OVERFLOW;
								end else begin
									cmd.push = 1'b1;
								end
							end
							CL_OP: begin
								if (sts.lt2) begin
									cmd.set_err  = 1'b1;
									cmd.err_code = ST_UNDERFLOW;
								end else begin
									cmd.load_op = 1'b1;
									state_d     = S_EXEC;
								end
							end
							CL_INVALID: begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ST_INVALID;
							end
							default: begin
							end
						endcase
					end
				end
			end
			S_EXEC: begin
				if (sts.op == OP_DIV) begin
					if (sts.rhs_zero) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_DIVZERO;
						state_d      = after_op;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end else begin
					cmd.alu_wb = 1'b1;
					state_d    = after_op;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.div_wb = 1'b1;
					state_d    = after_op;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			last_q      <= last_d;
			out_valid_q <= cmd.finish || (out_valid_q && !m_tready);
		end
	end

endmodule

// File: rtl/postfix_expression_evaluator_unit.sv
// Postfix expression evaluator: input stream of characters, output stream of results.
// Top level joining pee_ctrl and pee_dp; depends on pee_pkg and assert_macros.svh.
//
// The input channel takes one ASCII character per word, with tlast on the final
// character of an expression. Digits push 0 to 9, a space is skipped, and the
// operators + - * / pop two values and push the 32-bit wrapped result.
// After the final character the output channel carries one word: the top value
// (tdata) and a status code (tuser): ok, invalid character, underflow, divide by
// zero or overflow. The first error of an expression sticks until its end, and
// the value is zero whenever the status is not ok.
// Sequencing: a digit, space or invalid character is taken in the idle state; + - *
// go on to the execute state (registered stack RAM read, then the ALU), and / to the
// execute and divide states, as the divider resolves one quotient bit per cycle. The
// final character adds the finish state to load the output, valid on the next cycle.
// The output register lets the next expression start while a result still waits;
// only a second final character stalls the input until the waiting word is taken.
// Reset empties the stack and clears the error and the output valid flag; the
// stack RAM itself is not cleared, since only written entries are ever read.
`include "assert_macros.svh"

module postfix_expression_evaluator_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] character
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value, two's complement
	output logic [2:0]  m_tuser    // [2:0] status
);
	import pee_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller: owns the state, the pending final flag and the output valid bit.
	pee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.m_tready (m_tready),
		.sts      (sts),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	// Datapath: stack, arithmetic and the registered result word.
	pee_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.character (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.value     (m_tdata),
		.status    (m_tuser)
	);

	// A new result must never overwrite a word that is still waiting.
	`ASSERT_IMPLY(a_no_overwrite, cmd.finish, !m_tvalid || m_tready, "result overwritten")
	// A loaded result shows up on the output the next cycle.
	`ASSERT_IMPLY_NEXT(a_finish_valid, cmd.finish, m_tvalid, "result not presented")
	// A digit is never pushed onto a full stack.
	`ASSERT_IMPLY(a_push_room, cmd.push, !sts.full, "push onto full stack")
	// An operator only writes back with two operands stacked.
	`ASSERT_IMPLY(a_wb_operands, cmd.alu_wb || cmd.div_wb, !sts.lt2, "operator underflow")

endmodule
